// ----- sv/abs_pkg.sv -----
// shared types and constants for the ascending sorter
package abs_pkg;

  localparam int SLOTS  = 16;
  localparam int DATA_W = 32;
  localparam int CNT_W  = $clog2(SLOTS + 1);

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic                     is_last;
  } in_word_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] sorted_value;
    logic                     last_out;
    logic                     overflow;
  } out_word_t;

  // controls broadcast to every cell
  typedef struct packed {
    logic insert;
    logic shift;
  } cell_ctrl_t;

endpackage

// ----- sv/abs_cell.sv -----
// one sorting cell: holds one element, inserts in order or shifts towards the head
module abs_cell
  import abs_pkg::*;
(
  input  logic                     clk,
  input  cell_ctrl_t               ctrl,
  input  logic                     occupied,
  input  logic signed [DATA_W-1:0] new_value,
  input  logic signed [DATA_W-1:0] left_value,
  input  logic                     left_less,
  input  logic signed [DATA_W-1:0] right_value,
  output logic signed [DATA_W-1:0] value,
  output logic                     less
);

  // new element belongs ahead of this one; an empty cell counts as +infinity
  assign less = !occupied || (new_value < value);

  always_ff @(posedge clk) begin
    if (ctrl.insert) begin
      if (left_less) begin
        value <= left_value;
      end else if (less) begin
        value <= new_value;
      end
    end else if (ctrl.shift) begin
      value <= right_value;
    end
  end

endmodule

// ----- sv/abs_ctrl.sv -----
// load / drain sequencer with fill count and overflow flag
module abs_ctrl
  import abs_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic             in_last,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  output cell_ctrl_t       ctrl,
  output logic [CNT_W-1:0] count,
  output logic             overflow_seen
);

  typedef enum logic [1:0] {
    ST_LOAD  = 2'b01,
    ST_DRAIN = 2'b10
  } state_t;

  state_t state, state_next;
  logic [CNT_W-1:0] count_next;
  logic overflow_next;
  logic in_acc, out_acc, has_room;

  assign in_ready  = (state == ST_LOAD);
  assign out_valid = (state == ST_DRAIN);
  assign in_acc    = in_valid && in_ready;
  assign out_acc   = out_valid && out_ready;
  assign has_room  = (count < CNT_W'(SLOTS));

  assign ctrl.insert = in_acc && has_room;
  assign ctrl.shift  = out_acc;

  always_comb begin
    state_next    = state;
    count_next    = count;
    overflow_next = overflow_seen;
    case (state)
      ST_LOAD: begin
        if (in_acc) begin
          if (has_room) begin
            count_next = count + CNT_W'(1);
          end else begin
            overflow_next = 1'b1;
          end
          if (in_last) begin
            state_next = ST_DRAIN;
          end
        end
      end
      ST_DRAIN: begin
        if (out_acc) begin
          count_next = count - CNT_W'(1);
          if (count == CNT_W'(1)) begin
            state_next    = ST_LOAD;
            overflow_next = 1'b0;
          end
        end
      end
      default: begin
        state_next    = ST_LOAD;
        count_next    = '0;
        overflow_next = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_LOAD;
      count         <= '0;
      overflow_seen <= 1'b0;
    end else begin
      state         <= state_next;
      count         <= count_next;
      overflow_seen <= overflow_next;
    end
  end

endmodule

// ----- sv/ascending_bubble_sorter.sv -----
// top level: sequencer plus a row of insertion cells
//
//   channel | direction | word       | fields
//   in      | input     | in_word_t  | value, is_last
//   out     | output    | out_word_t | sorted_value, last_out, overflow
//
// loading can take a new word right behind the last; each word is placed in order
// as it arrives, with every cell comparing against the incoming word at once.
// after the closing word, the set drains one word per cycle from the head cell
// while out is ready; input is held off while a set drains,
// and a stall on out simply holds the row.
// synchronous reset empties the row; no clearing pass is needed.
module ascending_bubble_sorter
  import abs_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_data
);

  cell_ctrl_t       ctrl;
  logic [CNT_W-1:0] count;
  logic             overflow_seen;

  logic signed [DATA_W-1:0] cell_value [SLOTS];
  logic                     cell_less  [SLOTS];

  abs_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_last       (in_data.is_last),
    .in_ready      (in_ready),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .ctrl          (ctrl),
    .count         (count),
    .overflow_seen (overflow_seen)
  );

  for (genvar g = 0; g < SLOTS; g++) begin : g_cell
    logic signed [DATA_W-1:0] left_value, right_value;
    logic                     left_less, occupied;

    assign occupied = (count > CNT_W'(g));

    if (g == 0) begin : g_head
      assign left_value = '0;
      assign left_less  = 1'b0;
    end else begin : g_body
      assign left_value = cell_value[g-1];
      assign left_less  = cell_less[g-1];
    end

    if (g == SLOTS - 1) begin : g_tail
      assign right_value = '0;
    end else begin : g_mid
      assign right_value = cell_value[g+1];
    end

    abs_cell u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .occupied    (occupied),
      .new_value   (in_data.value),
      .left_value  (left_value),
      .left_less   (left_less),
      .right_value (right_value),
      .value       (cell_value[g]),
      .less        (cell_less[g])
    );
  end

  assign out_data.sorted_value = cell_value[0];
  assign out_data.last_out     = (count == CNT_W'(1));
  assign out_data.overflow     = overflow_seen;

endmodule

// ----- sv/abs_checker.sv -----
// port-level checks for the ascending sorter, bound to the top level
module abs_checker
  import abs_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      in_valid,
  input logic      in_ready,
  input in_word_t  in_data,
  input logic      out_valid,
  input logic      out_ready,
  input out_word_t out_data
);

  // a stalled output word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output word changed while stalled");

  // loading and draining never overlap
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("input open while draining");

  // closing word starts the drain
  a_close_drains: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_data.is_last |=> out_valid)
    else $error("no output after closing word");

  // final word reopens input
  a_last_reopens: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && out_data.last_out |=> in_ready && !out_valid)
    else $error("input not reopened after final word");

  // words come out in ascending order
  a_ascending: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !out_data.last_out |=>
      out_valid && (out_data.sorted_value >= $past(out_data.sorted_value)))
    else $error("output not ascending");

endmodule

bind ascending_bubble_sorter abs_checker u_abs_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

// ----- sim/ascending_bubble_sorter_tb.sv -----
// self-checking testbench for the ascending bubble sorter
`timescale 1ns / 1ps

module ascending_bubble_sorter_tb;
  import abs_pkg::*;

  localparam int ITEMS     = 470;
  localparam int LONG_HOLD = 300;
  localparam int DIR_ROWS  = 9;
  localparam logic signed [DATA_W-1:0] SMIN = {1'b1, {(DATA_W-1){1'b0}}};
  localparam logic signed [DATA_W-1:0] SMAX = {1'b0, {(DATA_W-1){1'b1}}};

  typedef struct packed {
    in_word_t   word;
    logic [4:0] reps;
    logic       typed;
    out_word_t  want;
  } stim_row_t;

  logic      clk       = 1'b0;
  logic      rst       = 1'b1;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_word_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_word_t out_data;

  // sorter image: words held for the open set
  logic signed [DATA_W-1:0] held [SLOTS];
  int        held_count  = 0;
  logic      dropped_any = 1'b0;
  out_word_t sorted_run [SLOTS];

  out_word_t pending_sorted [$];
  int        mismatch_count = 0;
  int        words_sent     = 0;
  int        tx_max         = 12;
  int        rx_max         = 12;
  bit        hold_long      = 1'b0;
  stim_row_t dir_table [DIR_ROWS];

  ascending_bubble_sorter uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("ascending_bubble_sorter_tb NOT OK");
    $finish;
  end

  task automatic report_mismatch(string msg);
    if (mismatch_count < 50) $display("%0t mismatch: %s", $time, msg);
    mismatch_count++;
  endtask

  // takes one accepted word, returns how many sorted words it releases
  function automatic int absorb_word(in_word_t w);
    logic signed [DATA_W-1:0] v;
    int n;
    int j;
    if (held_count < SLOTS) begin
      held[held_count] = w.value;
      held_count++;
    end else begin
      dropped_any = 1'b1;
    end
    if (!w.is_last) return 0;
    n = held_count;
    // insertion sort, stable among equals
    for (int i = 1; i < n; i++) begin
      v = held[i];
      j = i;
      while (j > 0 && held[j-1] > v) begin
        held[j] = held[j-1];
        j--;
      end
      held[j] = v;
    end
    for (int k = 0; k < n; k++)
      sorted_run[k] = '{sorted_value: held[k], last_out: (k == n - 1),
                        overflow: dropped_any};
    held_count  = 0;
    dropped_any = 1'b0;
    return n;
  endfunction

  function automatic logic signed [DATA_W-1:0] pick_value();
    logic signed [DATA_W-1:0] v;
    case ($urandom_range(0, 9))
      0: v = SMIN;
      1: v = SMAX;
      2: v = $urandom_range(0, 1) ? '0 : '1;
      3, 4, 5: begin
        v = $urandom_range(0, 15);
        v = v - 8;
      end
      default: v = $urandom;
    endcase
    return v;
  endfunction

  function automatic int pick_size();
    int n;
    case ($urandom_range(0, 9))
      0: n = $urandom_range(SLOTS + 1, SLOTS + 4);
      1: n = SLOTS;
      2: n = 1;
      default: n = $urandom_range(2, 8);
    endcase
    return n;
  endfunction

  task automatic send_word(in_word_t w, logic typed, out_word_t want);
    int gap;
    int n;
    gap = (tx_max > 0) ? $urandom_range(0, tx_max) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_data  <= w;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    words_sent++;
    n = absorb_word(w);
    if (typed) begin
      pending_sorted.push_back(want);
    end else begin
      for (int k = 0; k < n; k++) pending_sorted.push_back(sorted_run[k]);
    end
  endtask

  task automatic send_set(int n);
    in_word_t w;
    for (int i = 0; i < n; i++) begin
      w.value   = pick_value();
      w.is_last = (i == n - 1);
      send_word(w, 1'b0, '0);
    end
  endtask

  // drop valid before the set finishes draining, so the closing word is not taken twice
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_sorted.size() != 0) @(posedge clk);
  endtask

  task automatic take_result(out_word_t got);
    out_word_t want;
    if (pending_sorted.size() == 0) begin
      report_mismatch($sformatf("unexpected word value %0d", got.sorted_value));
      return;
    end
    want = pending_sorted.pop_front();
    if (got.sorted_value !== want.sorted_value)
      report_mismatch($sformatf("sorted_value %0d, want %0d",
                                got.sorted_value, want.sorted_value));
    if (got.last_out !== want.last_out)
      report_mismatch($sformatf("last_out %b, want %b", got.last_out, want.last_out));
    if (got.overflow !== want.overflow)
      report_mismatch($sformatf("overflow %b, want %b", got.overflow, want.overflow));
  endtask

  // receiver: ready ahead of the word, a stall once the word shows, or a long hold when asked for
  initial begin
    int stall;
    wait (rst == 1'b0);
    forever begin
      @(negedge clk);
      if (hold_long) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        hold_long = 1'b0;
        out_ready <= 1'b1;
      end else begin
        stall = (rx_max > 0) ? $urandom_range(0, rx_max) : 0;
        if (stall == 0) begin
          out_ready <= 1'b1;
        end else begin
          out_ready <= 1'b0;
          do @(posedge clk); while (!out_valid);
          repeat (stall) @(negedge clk);
          out_ready <= 1'b1;
        end
      end
      do @(posedge clk); while (!out_valid);
      take_result(out_data);
    end
  end

  initial begin
    int phase;
    dir_table = '{
      '{'{'0, 1'b1},     5'd1,  1'b1, '{'0, 1'b1, 1'b0}},
      '{'{SMIN, 1'b1},   5'd1,  1'b1, '{SMIN, 1'b1, 1'b0}},
      '{'{SMAX, 1'b1},   5'd1,  1'b1, '{SMAX, 1'b1, 1'b0}},
      '{'{SMAX, 1'b0},   5'd1,  1'b0, '0},
      '{'{SMIN, 1'b0},   5'd1,  1'b0, '0},
      '{'{'0, 1'b0},     5'd1,  1'b0, '0},
      '{'{'1, 1'b1},     5'd1,  1'b0, '0},
      // fill the store with equal words, then a closing word that is dropped
      '{'{32'sd5, 1'b0}, 5'd16, 1'b0, '0},
      '{'{32'sd9, 1'b1}, 5'd1,  1'b0, '0}
    };
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int r = 0; r < DIR_ROWS; r++)
      for (int k = 0; k < dir_table[r].reps; k++)
        send_word(dir_table[r].word, dir_table[r].typed, dir_table[r].want);
    wait_drained();

    phase = 0;
    while (words_sent < ITEMS) begin
      case (phase % 4)
        0: begin tx_max = 12; rx_max = 12; end
        1: begin tx_max = 0;  rx_max = 0;  end
        2: begin tx_max = 0;  rx_max = 12; end
        default: begin tx_max = 12; rx_max = 0; end
      endcase
      // sink stops while full sets keep coming, so the input backs up
      if (phase == 1) begin
        hold_long = 1'b1;
        repeat (3) send_set(SLOTS);
      end
      for (int s = 0; s < 6 && words_sent < ITEMS; s++) send_set(pick_size());
      wait_drained();
      phase++;
    end

    @(negedge clk);
    in_valid <= 1'b0;
    wait_drained();
    repeat (40) @(posedge clk);
    if (mismatch_count == 0)
      $display("ascending_bubble_sorter_tb OK");
    else
      $display("ascending_bubble_sorter_tb NOT OK");
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/abs_pkg.sv
sv/abs_cell.sv
sv/abs_ctrl.sv
sv/ascending_bubble_sorter.sv
sv/abs_checker.sv
sim/ascending_bubble_sorter_tb.sv
